[rtl/ddwcf_pkg.sv]
package ddwcf_pkg;

    localparam int SPEED_W    = 25;
    localparam int RADIUS_W   = 20;
    localparam int SEP_W      = 22;
    localparam int MAXS_W     = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 22;

    // |N| < 2^47, so wheel magnitudes fit 48 bits; D < 2^60; 100*D < 2^67
    localparam int MAG_W  = 48;
    localparam int PROD_W = 48;
    localparam int NSUM_W = 49;
    localparam int DEN_W  = 60;
    localparam int RM_W   = 37;
    localparam int DIV_W  = 67;
    localparam int Q_W    = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXS   = 4'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 20'd50000;
    localparam logic [SEP_W-1:0]    SEP_RST    = 22'd300000;
    localparam logic [MAXS_W-1:0]   MAXS_RST   = 17'd2000;

    // 40 * pi, pi in Q16 (205887 / 2^16)
    localparam logic [22:0] DEN_K = 23'd8235480;
    localparam logic signed [22:0] LIN_K = 23'sd2000000;

    localparam logic signed [SPEED_W-1:0] SLOW_LIN  = 25'sd100000;
    localparam logic signed [SPEED_W-1:0] ANG_DEAD  = 25'sd200;
    localparam logic signed [SPEED_W-1:0] ANG_FLOOR = 25'sd150000;
    localparam logic signed [SPEED_W-1:0] LIN_FLOOR = 25'sd50000;

    localparam logic [Q_W-1:0] PCT_MAX = 7'd100;

    localparam int FRAME_LEN = 13;
    localparam int HDR_LEN   = 5;
    localparam logic [7:0] HDR [HDR_LEN] = '{8'hcd, 8'heb, 8'hd7, 8'h09, 8'h74};
    localparam logic [7:0] DIR_F = 8'h46;
    localparam logic [7:0] DIR_B = 8'h42;
    localparam logic [7:0] DIR_S = 8'h53;

    localparam logic [3:0] POS_DIR_R = 4'd5;
    localparam logic [3:0] POS_DIR_L = 4'd6;
    localparam logic [3:0] POS_PAD0  = 4'd7;
    localparam logic [3:0] POS_PAD1  = 4'd8;
    localparam logic [3:0] POS_MAG_R = 4'd9;
    localparam logic [3:0] POS_MAG_L = 4'd10;
    localparam logic [3:0] POS_LAST  = 4'd12;

    typedef struct packed {
        logic [MAG_W-1:0] mag_r;
        logic [MAG_W-1:0] mag_l;
        logic [MAG_W-1:0] mag_max;
        logic             neg_r;
        logic             neg_l;
        logic             enable;
    } cmd_work_t;

    typedef struct packed {
        logic [7:0] dir_r;
        logic [7:0] dir_l;
        logic [7:0] mag_r;
        logic [7:0] mag_l;
    } wheel_cmd_t;

endpackage

[rtl/ddwcf_cmd_if.sv]
interface ddwcf_cmd_if;
    import ddwcf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] angular_rate;
    logic                      base_ready;
    logic                      move_enable;

    modport source (output valid, linear_speed, angular_rate, base_ready, move_enable,
                    input ready);
    modport sink (input valid, linear_speed, angular_rate, base_ready, move_enable,
                  output ready);
endinterface

[rtl/ddwcf_frame_if.sv]
interface ddwcf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

[rtl/ddwcf_cfg_if.sv]
interface ddwcf_cfg_if;
    import ddwcf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/ddwcf_cfg_regs.sv]
module ddwcf_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    ddwcf_cfg_if.sink                    cfg,
    output logic [ddwcf_pkg::SEP_W-1:0]  sep,
    output logic [ddwcf_pkg::DEN_W-1:0]  den
);
    import ddwcf_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic [SEP_W-1:0]    sep_reg;
    logic [MAXS_W-1:0]   maxs_reg;
    logic [RADIUS_W-1:0] radius_eff;
    logic [MAXS_W-1:0]   maxs_eff;
    logic [RM_W-1:0]     rm_reg, rm_next;
    logic [41:0]         lo_reg, lo_next;
    logic [40:0]         hi_reg, hi_next;
    logic [DEN_W-1:0]    den_reg, den_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            sep_reg    <= SEP_RST;
            maxs_reg   <= MAXS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RADIUS: radius_reg <= cfg.data[RADIUS_W-1:0];
                REG_SEP:    sep_reg    <= cfg.data[SEP_W-1:0];
                REG_MAXS:   maxs_reg   <= cfg.data[MAXS_W-1:0];
                default:    ;
            endcase
        end
    end

    // divisor D = 40*pi*r*max, rebuilt continuously over three stages
    always_comb
    begin
        radius_eff = (radius_reg == '0) ? RADIUS_W'(1) : radius_reg;
        maxs_eff   = (maxs_reg == '0) ? MAXS_W'(1) : maxs_reg;
        rm_next    = RM_W'(radius_eff) * RM_W'(maxs_eff);
        lo_next    = 42'(rm_reg[18:0]) * 42'(DEN_K);
        hi_next    = 41'(rm_reg[RM_W-1:19]) * 41'(DEN_K);
        den_next   = DEN_W'(lo_reg) + (DEN_W'(hi_reg) << 19);
    end

    always_ff @(posedge clk)
    begin
        rm_reg  <= rm_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        den_reg <= den_next;
    end

    assign sep = sep_reg;
    assign den = den_reg;
endmodule

[rtl/ddwcf_front.sv]
module ddwcf_front #(
    parameter int DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ddwcf_cmd_if.sink                        cmd,
    input  logic [ddwcf_pkg::SEP_W-1:0]      sep,
    input  logic [$clog2(DEPTH+1)-1:0]       level,
    output logic                             push,
    output ddwcf_pkg::cmd_work_t             entry
);
    import ddwcf_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);

    logic                       accept;
    logic                       slow;
    logic signed [SPEED_W-1:0]  x_f, z_f;
    logic signed [SEP_W:0]      sep_s;
    logic [LW+1:0]              occupancy;

    logic                       v1_reg, v2_reg, v3_reg;
    logic signed [SPEED_W-1:0]  x1_reg, z1_reg;
    logic                       en1_reg, en2_reg, en3_reg;
    logic signed [PROD_W-1:0]   px2_reg, pz2_reg, px2_next, pz2_next;
    logic signed [NSUM_W-1:0]   nr3_reg, nl3_reg, nr3_next, nl3_next;
    logic [NSUM_W-1:0]          abs_r, abs_l;

    // slots in use: queue level plus items already in the pipeline
    assign occupancy = (LW+2)'(level) + (LW+2)'(v1_reg) + (LW+2)'(v2_reg)
                     + (LW+2)'(v3_reg);
    assign cmd.ready = occupancy < (LW+2)'(DEPTH);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        slow = (cmd.linear_speed > -SLOW_LIN) && (cmd.linear_speed < SLOW_LIN);
        z_f  = cmd.angular_rate;
        if (slow)
        begin
            if (cmd.angular_rate > ANG_DEAD && cmd.angular_rate < ANG_FLOOR)
                z_f = ANG_FLOOR;
            if (cmd.angular_rate < -ANG_DEAD && cmd.angular_rate > -ANG_FLOOR)
                z_f = -ANG_FLOOR;
        end
        x_f = cmd.linear_speed;
        if (cmd.linear_speed > 0 && cmd.linear_speed < LIN_FLOOR)
            x_f = LIN_FLOOR;
        if (cmd.linear_speed < 0 && cmd.linear_speed > -LIN_FLOOR)
            x_f = -LIN_FLOOR;
    end

    always_comb
    begin
        sep_s    = $signed({1'b0, sep});
        px2_next = PROD_W'(x1_reg) * PROD_W'(LIN_K);
        pz2_next = PROD_W'(z1_reg) * PROD_W'(sep_s);
        nr3_next = NSUM_W'(px2_reg) + NSUM_W'(pz2_reg);
        nl3_next = NSUM_W'(px2_reg) - NSUM_W'(pz2_reg);
        abs_r    = nr3_reg[NSUM_W-1] ? (NSUM_W'(0) - nr3_reg) : nr3_reg;
        abs_l    = nl3_reg[NSUM_W-1] ? (NSUM_W'(0) - nl3_reg) : nl3_reg;
        entry.mag_r   = abs_r[MAG_W-1:0];
        entry.mag_l   = abs_l[MAG_W-1:0];
        entry.mag_max = (abs_l > abs_r) ? abs_l[MAG_W-1:0] : abs_r[MAG_W-1:0];
        entry.neg_r   = nr3_reg[NSUM_W-1];
        entry.neg_l   = nl3_reg[NSUM_W-1];
        entry.enable  = en3_reg;
    end

    assign push = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept && cmd.base_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= x_f;
        z1_reg  <= z_f;
        en1_reg <= cmd.move_enable;
        px2_reg <= px2_next;
        pz2_reg <= pz2_next;
        en2_reg <= en1_reg;
        nr3_reg <= nr3_next;
        nl3_reg <= nl3_next;
        en3_reg <= en2_reg;
    end
endmodule

[rtl/ddwcf_queue.sv]
module ddwcf_queue #(
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  ddwcf_pkg::cmd_work_t         entry,
    input  logic                         pop,
    output ddwcf_pkg::cmd_work_t         head,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    import ddwcf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    cmd_work_t        slot_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [LW-1:0]    level_reg, level_next;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        level_next = level_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            level_next = level_reg + LW'(1);
        else if (pop && !push)
            level_next = level_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= entry;
    end

    assign head  = slot_reg[rd_reg];
    assign level = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> level_reg < LW'(DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("queue read while empty");
endmodule

[rtl/ddwcf_div.sv]
module ddwcf_div #(
    parameter int DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddwcf_pkg::cmd_work_t          head,
    input  logic [$clog2(DEPTH+1)-1:0]    level,
    input  logic [ddwcf_pkg::DEN_W-1:0]   den,
    output logic                          pop,
    output ddwcf_pkg::wheel_cmd_t         res,
    output logic                          res_valid,
    input  logic                          take
);
    import ddwcf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       step_reg, step_next;
    cmd_work_t        work_reg;
    logic [DIV_W-1:0] rem_r_reg, rem_r_next, rem_l_reg, rem_l_next;
    logic [DIV_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_r_reg, q_r_next, q_l_reg, q_l_next;
    logic [DIV_W-1:0] hund_den, hi_max, num_r, num_l, divisor;
    logic             scaled, ge_r, ge_l;

    function automatic logic [15:0] wheel_bytes(logic [Q_W-1:0] q, logic neg, logic en);
        logic [Q_W-1:0] p;
        logic [7:0]     d;
        p = (q > PCT_MAX) ? PCT_MAX : q;
        if (p == '0)
            d = DIR_S;
        else
            d = neg ? DIR_B : DIR_F;
        if (!en)
            d = DIR_S;
        return {d, 1'b0, p};
    endfunction

    always_comb
    begin
        hund_den = (DIV_W'(den) << 6) + (DIV_W'(den) << 5) + (DIV_W'(den) << 2);
        hi_max   = DIV_W'(work_reg.mag_max) << 16;
        scaled   = hi_max > hund_den;
        if (scaled)
        begin
            num_r   = (DIV_W'(work_reg.mag_r) << 6) + (DIV_W'(work_reg.mag_r) << 5)
                    + (DIV_W'(work_reg.mag_r) << 2);
            num_l   = (DIV_W'(work_reg.mag_l) << 6) + (DIV_W'(work_reg.mag_l) << 5)
                    + (DIV_W'(work_reg.mag_l) << 2);
            divisor = DIV_W'(work_reg.mag_max);
        end
        else
        begin
            num_r   = DIV_W'(work_reg.mag_r) << 16;
            num_l   = DIV_W'(work_reg.mag_l) << 16;
            divisor = DIV_W'(den);
        end
        ge_r = rem_r_reg >= dsh_reg;
        ge_l = rem_l_reg >= dsh_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_r_next = rem_r_reg;
        rem_l_next = rem_l_reg;
        dsh_next   = dsh_reg;
        q_r_next   = q_r_reg;
        q_l_next   = q_l_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (level != '0)
                begin
                    pop        = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                rem_r_next = num_r;
                rem_l_next = num_l;
                dsh_next   = divisor << 6;
                q_r_next   = '0;
                q_l_next   = '0;
                step_next  = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // one restoring quotient bit per wheel, shared shifted divisor
                rem_r_next = ge_r ? rem_r_reg - dsh_reg : rem_r_reg;
                rem_l_next = ge_l ? rem_l_reg - dsh_reg : rem_l_reg;
                q_r_next   = {q_r_reg[Q_W-2:0], ge_r};
                q_l_next   = {q_l_reg[Q_W-2:0], ge_l};
                dsh_next   = dsh_reg >> 1;
                step_next  = step_reg + 3'd1;
                if (step_reg == 3'(Q_W - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            work_reg <= head;
        rem_r_reg <= rem_r_next;
        rem_l_reg <= rem_l_next;
        dsh_reg   <= dsh_next;
        q_r_reg   <= q_r_next;
        q_l_reg   <= q_l_next;
    end

    always_comb
    begin
        {res.dir_r, res.mag_r} = wheel_bytes(q_r_reg, work_reg.neg_r, work_reg.enable);
        {res.dir_l, res.mag_l} = wheel_bytes(q_l_reg, work_reg.neg_l, work_reg.enable);
    end

    assign res_valid = (state_reg == ST_DONE);

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (q_r_reg <= PCT_MAX) && (q_l_reg <= PCT_MAX))
        else $error("wheel percentage above full scale");

    a_take_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == ST_DONE)
        else $error("result taken before division finished");
endmodule

[rtl/ddwcf_ser.sv]
module ddwcf_ser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ddwcf_pkg::wheel_cmd_t  res,
    input  logic                   res_valid,
    output logic                   take,
    ddwcf_frame_if.source          frame
);
    import ddwcf_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    wheel_cmd_t  cmd_reg;
    logic        xfer, last;

    assign xfer = frame.valid && frame.ready;
    assign last = (cnt_reg == POS_LAST);
    assign take = res_valid && (!busy_reg || (xfer && last));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (xfer)
        begin
            if (last)
                busy_next = 1'b0;
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= res;
    end

    always_comb
    begin
        case (cnt_reg)
            POS_DIR_R: frame.frame_byte = cmd_reg.dir_r;
            POS_DIR_L: frame.frame_byte = cmd_reg.dir_l;
            POS_PAD0:  frame.frame_byte = DIR_S;
            POS_PAD1:  frame.frame_byte = DIR_S;
            POS_MAG_R: frame.frame_byte = cmd_reg.mag_r;
            POS_MAG_L: frame.frame_byte = cmd_reg.mag_l;
            default:
            begin
                if (cnt_reg < 4'(HDR_LEN))
                    frame.frame_byte = HDR[cnt_reg[2:0]];
                else
                    frame.frame_byte = 8'h00;
            end
        endcase
    end

    assign frame.valid      = busy_reg;
    assign frame.frame_last = last;

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy_reg && (cnt_reg == '0))
        else $error("frame load did not restart the byte counter");
endmodule

[rtl/diff_drive_wheel_command_framer_top.sv]
// Differential-drive wheel command framer.
// cmd   : one body velocity command per transfer (linear um/s, yaw urad/s,
//         base_ready, move_enable). Commands with base_ready low are dropped.
// frame : 13 bytes per command, CD EB D7 09 74 dirR dirL 53 53 magR magL 00 00,
//         frame_last marks the thirteenth byte.
// cfg   : register writes (0 radius, 1 separation, 2 max wheel speed), always
//         ready; write only while no command is in flight.
// Path: from a command transfer to the first frame byte come the front stages,
// the queue write, the pop, a setup state, 7 restoring-division steps and the
// load into the byte serializer.
// Output: one frame byte per cycle while frame.ready is high; the divider
// finishes the next command while the current frame drains.
// cmd is taken every cycle while the front pipeline plus queue have room.
// Reset: registers return to 50000 / 300000 / 2000, queue and frame empty.
// Stalls on frame hold the current byte; commands back up into the queue
// and then cmd.ready drops.
module diff_drive_wheel_command_framer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    ddwcf_cmd_if.sink      cmd,
    ddwcf_frame_if.source  frame,
    ddwcf_cfg_if.sink      cfg
);
    import ddwcf_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [SEP_W-1:0] sep;
    logic [DEN_W-1:0] den;
    logic [LW-1:0]    level;
    logic             push, pop, res_valid, take;
    cmd_work_t        entry, head;
    wheel_cmd_t       res;

    ddwcf_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .sep   (sep),
        .den   (den)
    );

    ddwcf_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sep   (sep),
        .level (level),
        .push  (push),
        .entry (entry)
    );

    ddwcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (entry),
        .pop   (pop),
        .head  (head),
        .level (level)
    );

    ddwcf_div #(.DEPTH(QUEUE_DEPTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .level     (level),
        .den       (den),
        .pop       (pop),
        .res       (res),
        .res_valid (res_valid),
        .take      (take)
    );

    ddwcf_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .take      (take),
        .frame     (frame)
    );
endmodule
